/* rtl/dstwr_pkg.sv */
// ----------------------------------------------------------------------------
// dstwr_pkg
// Types and constants shared by the two-way ranging time-of-flight block.
// ----------------------------------------------------------------------------
package dstwr_pkg;

  // distance scale, cm per tick in q16
  localparam logic [14:0] CmPerTickQ16 = 15'd30744;
  localparam logic [15:0] DistMax      = 16'hFFFF;

  // interval queue between front and back
  localparam int QDepth   = 2;
  localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW    = $clog2(QDepth + 1);

  // one quotient bit per divider step
  localparam int DivSteps = 64;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [31:0] poll_sent_remote;
    logic [31:0] reply_got_remote;
    logic [31:0] final_sent_remote;
    logic [31:0] poll_got_local;
    logic [31:0] reply_sent_local;
    logic [31:0] final_got_local;
  } stamps_t;

  typedef struct packed {
    logic signed [32:0] flight_ticks;
    logic [15:0]        distance_cm;
    logic               clipped;
    logic               zero_divisor;
  } result_t;

  // intervals of one exchange as handed from front to back
  typedef struct packed {
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] da;
    logic [31:0] db;
    logic [33:0] sum;
    logic        zero;
  } ivl_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULA = 7'b0000010,
    S_MULB = 7'b0000100,
    S_SUB  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DIST = 7'b0100000,
    S_DONE = 7'b1000000
  } back_state_e;

endpackage

/* rtl/dstwr_front.sv */
// ----------------------------------------------------------------------------
// dstwr_front
// Takes the six timestamps, forms the four wrapping intervals and their sum.
// ----------------------------------------------------------------------------
module dstwr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dstwr_pkg::stamps_t in_data_i,
  output logic              ivl_valid_o,
  input  logic              ivl_ready_i,
  output dstwr_pkg::ivl_t   ivl_o
);
  import dstwr_pkg::*;

  logic  valid_q;
  ivl_t  ivl_q;
  ivl_t  ivl_d;

  always_comb begin
    ivl_d.ra   = in_data_i.reply_got_remote - in_data_i.poll_sent_remote;
    ivl_d.rb   = in_data_i.final_got_local - in_data_i.reply_sent_local;
    ivl_d.da   = in_data_i.final_sent_remote - in_data_i.reply_got_remote;
    ivl_d.db   = in_data_i.reply_sent_local - in_data_i.poll_got_local;
    ivl_d.sum  = {2'b00, ivl_d.ra} + {2'b00, ivl_d.rb}
               + {2'b00, ivl_d.da} + {2'b00, ivl_d.db};
    ivl_d.zero = (ivl_d.sum == 34'd0);
  end

  assign in_ready_o  = !valid_q || ivl_ready_i;
  assign ivl_valid_o = valid_q;
  assign ivl_o       = ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ivl_q <= ivl_d;
    end
  end

endmodule

/* rtl/dstwr_queue.sv */
// ----------------------------------------------------------------------------
// dstwr_queue
// Short first-in first-out queue of interval sets between front and back.
// ----------------------------------------------------------------------------
module dstwr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dstwr_pkg::ivl_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dstwr_pkg::ivl_t pop_data_o
);
  import dstwr_pkg::*;

  ivl_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/dstwr_back.sv */
// ----------------------------------------------------------------------------
// dstwr_back
// Products, signed difference, radix-2 division and distance scaling.
// ----------------------------------------------------------------------------
module dstwr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ivl_valid_i,
  output logic               ivl_ready_o,
  input  dstwr_pkg::ivl_t    ivl_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dstwr_pkg::result_t out_data_o
);
  import dstwr_pkg::*;

  back_state_e        state_q, state_d;
  ivl_t               ivl_q;
  logic [63:0]        p1_q, p2_q;
  logic [63:0]        quo_q;
  logic [33:0]        rem_q;
  logic               neg_q;
  logic               zero_q;
  logic [DivCntW-1:0] cnt_q;
  logic [46:0]        prod_q;
  logic               out_valid_q;
  result_t            out_q;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [34:0]        rem_sh;
  logic [35:0]        diff;
  logic               fits;
  logic               slot_free;
  logic [32:0]        mag33;
  result_t            res_d;

  // one shared multiplier for both interval products
  assign mul_a = (state_q == S_MULA) ? ivl_q.ra : ivl_q.da;
  assign mul_b = (state_q == S_MULA) ? ivl_q.rb : ivl_q.db;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // restoring divider step
  assign rem_sh = {rem_q, quo_q[63]};
  assign diff   = {1'b0, rem_sh} - {2'b00, ivl_q.sum};
  assign fits   = !diff[35];

  assign slot_free   = !out_valid_q || out_ready_i;
  assign ivl_ready_o = (state_q == S_IDLE);

  always_comb begin
    mag33              = {1'b0, quo_q[31:0]};
    res_d.flight_ticks = neg_q ? (~mag33 + 33'd1) : mag33;
    res_d.clipped      = (prod_q[46:32] != '0);
    res_d.distance_cm  = res_d.clipped ? DistMax : prod_q[31:16];
    res_d.zero_divisor = zero_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (ivl_valid_i) state_d = ivl_i.zero ? S_DIST : S_MULA;
      S_MULA: state_d = S_MULB;
      S_MULB: state_d = S_SUB;
      S_SUB:  state_d = S_DIV;
      S_DIV:  if (cnt_q == DivCntW'(DivSteps - 1)) state_d = S_DIST;
      S_DIST: state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SUB) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ivl_q  <= ivl_i;
        zero_q <= ivl_i.zero;
        neg_q  <= 1'b0;
        quo_q  <= '0;
      end
      S_MULA: p1_q <= mul_p;
      S_MULB: p2_q <= mul_p;
      S_SUB: begin
        rem_q <= '0;
        if (p1_q >= p2_q) begin
          quo_q <= p1_q - p2_q;
          neg_q <= 1'b0;
        end else begin
          quo_q <= p2_q - p1_q;
          neg_q <= 1'b1;
        end
      end
      S_DIV: begin
        rem_q <= fits ? diff[33:0] : rem_sh[33:0];
        quo_q <= {quo_q[62:0], fits};
      end
      S_DIST: prod_q <= 47'(quo_q[31:0]) * 47'(CmPerTickQ16);
      S_DONE: if (slot_free) out_q <= res_d;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/ds_twr_time_of_flight.sv */
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight
// Asymmetric double-sided two-way ranging: flight time and distance.
// ----------------------------------------------------------------------------
// back end: one exchange at a time, through the shared 32x32 multiplier and the
//   64-step radix-2 divider; it takes a new exchange only when idle
// the front end and a 2-entry queue keep taking exchanges while the back works
// reset: asynchronous active low, clears queue, control state and valid flags
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dstwr_pkg::stamps_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dstwr_pkg::result_t  out_data_o
);
  import dstwr_pkg::*;

  logic fr_valid, fr_ready;
  ivl_t fr_ivl;
  logic bk_valid, bk_ready;
  ivl_t bk_ivl;

  dstwr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ivl_valid_o (fr_valid),
    .ivl_ready_i (fr_ready),
    .ivl_o       (fr_ivl)
  );

  dstwr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_ivl),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_ivl)
  );

  dstwr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ivl_valid_i (bk_valid),
    .ivl_ready_o (bk_ready),
    .ivl_i       (bk_ivl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // zero interval sum gives all-zero results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_divisor |->
      out_data_o.flight_ticks == 33'sd0 && out_data_o.distance_cm == 16'd0 &&
      !out_data_o.clipped)
    else $error("zero divisor result not cleared");

  // saturation flag only with full-scale distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |-> out_data_o.distance_cm == DistMax)
    else $error("clipped without saturated distance");

  // a nonzero distance needs a nonzero flight time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.distance_cm != 16'd0 |->
      out_data_o.flight_ticks != 33'sd0)
    else $error("distance without flight time");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-way ranging time-of-flight block.
// A driver sends timestamp sets from a queue, in bursts with random gaps.
// A monitor predicts each result and checks the results against it, and a
// receiver stalls the output on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dstwr_pkg::*;

  localparam logic [63:0] ScaleQ16   = 64'd30744;
  localparam logic [63:0] DistLimit  = 64'd65535;
  localparam int          RandomSets = 1100;
  localparam int          TailCycles = 150;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  stamps_t in_data_i   = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;

  stamps_t pending_sets[$];
  result_t ranging_due[$];

  logic in_taken = 1'b0;
  int   sets_sent     = 0;
  int   sets_taken    = 0;
  int   sets_total    = 0;
  int   first_hold    = 0;
  int   second_hold   = 0;
  int   burst_left    = 0;
  int   gap_left      = 0;
  int   stall_mode    = 0;
  int   stall_left    = 0;
  int   mismatch_count = 0;
  int   results_seen  = 0;
  int   zero_seen     = 0;
  int   clip_seen     = 0;
  int   neg_seen      = 0;

  ds_twr_time_of_flight dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // asymmetric flight time and distance of one exchange
  function automatic result_t range_exchange(stamps_t s);
    logic [31:0] ra, rb, da, db;
    logic [63:0] sum, p1, p2, mag, q, dist_cm;
    logic        neg;
    result_t     r;
    ra  = s.reply_got_remote - s.poll_sent_remote;
    da  = s.final_sent_remote - s.reply_got_remote;
    db  = s.reply_sent_local - s.poll_got_local;
    rb  = s.final_got_local - s.reply_sent_local;
    sum = {32'd0, ra} + {32'd0, rb} + {32'd0, da} + {32'd0, db};
    r   = '0;
    if (sum == 64'd0) begin
      r.zero_divisor = 1'b1;
      return r;
    end
    p1  = {32'd0, ra} * {32'd0, rb};
    p2  = {32'd0, da} * {32'd0, db};
    neg = (p1 < p2);
    mag = neg ? p2 - p1 : p1 - p2;
    q   = mag / sum;
    r.flight_ticks = neg ? -(q[32:0]) : q[32:0];
    dist_cm = (q * ScaleQ16) >> 16;
    if (dist_cm > DistLimit) begin
      r.distance_cm = DistLimit[15:0];
      r.clipped     = 1'b1;
    end else begin
      r.distance_cm = dist_cm[15:0];
    end
    return r;
  endfunction

  function automatic stamps_t stamps(logic [31:0] poll_tx, logic [31:0] resp_rx,
                                     logic [31:0] final_tx, logic [31:0] poll_rx,
                                     logic [31:0] resp_tx, logic [31:0] final_rx);
    stamps_t s;
    s.poll_sent_remote  = poll_tx;
    s.reply_got_remote  = resp_rx;
    s.final_sent_remote = final_tx;
    s.poll_got_local    = poll_rx;
    s.reply_sent_local  = resp_tx;
    s.final_got_local   = final_rx;
    return s;
  endfunction

  // consistent exchange: flight time tof, reply delays on both sides, skew on one leg
  function automatic stamps_t build_exchange(logic [31:0] t_rem, logic [31:0] t_loc,
                                             logic [31:0] tof, logic [31:0] rep_rem,
                                             logic [31:0] rep_loc, logic [31:0] skew);
    stamps_t s;
    s.poll_sent_remote  = t_rem;
    s.poll_got_local    = t_loc;
    s.reply_sent_local  = t_loc + rep_loc;
    s.reply_got_remote  = t_rem + (tof << 1) + rep_loc + skew;
    s.final_sent_remote = s.reply_got_remote + rep_rem;
    s.final_got_local   = s.reply_sent_local + (tof << 1) + rep_rem;
    return s;
  endfunction

  function automatic logic [31:0] pick_flight();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 32'($urandom_range(0, 3000));
    if (sel < 17) return 32'($urandom_range(0, 300000));
    if (sel < 19) return 32'($urandom_range(0, 1 << 24));
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_reply();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 32'($urandom_range(0, 5000));
    if (sel < 17) return 32'($urandom_range(0, 1 << 20));
    return $urandom;
  endfunction

  // driver: bursts with random gaps, holds twice until every result is back
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left   -= 1;
        in_valid_i <= 1'b0;
      end else if (pending_sets.size() != 0 &&
                   !((sets_sent == first_hold || sets_sent == second_hold) &&
                     ranging_due.size() != 0)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_sets.pop_front();
        sets_sent  += 1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
        end else begin
          burst_left -= 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: always ready, coin flip, or mostly stalled, in stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(50, 400);
      end else begin
        stall_left -= 1;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk_i) begin
    result_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      ranging_due.push_back(range_exchange(in_data_i));
      sets_taken += 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen += 1;
      if (ranging_due.size() == 0) begin
        $error("result with no exchange pending: flight_ticks %0d",
               out_data_o.flight_ticks);
        mismatch_count += 1;
      end else begin
        want = ranging_due.pop_front();
        if (want.zero_divisor) zero_seen += 1;
        if (want.clipped) clip_seen += 1;
        if (want.flight_ticks < 0) neg_seen += 1;
        if (out_data_o.flight_ticks !== want.flight_ticks) begin
          $error("flight_ticks: expected %0d, actual %0d",
                 want.flight_ticks, out_data_o.flight_ticks);
          mismatch_count += 1;
        end
        if (out_data_o.distance_cm !== want.distance_cm) begin
          $error("distance_cm: expected %0d, actual %0d",
                 want.distance_cm, out_data_o.distance_cm);
          mismatch_count += 1;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, out_data_o.clipped);
          mismatch_count += 1;
        end
        if (out_data_o.zero_divisor !== want.zero_divisor) begin
          $error("zero_divisor: expected %0b, actual %0b",
                 want.zero_divisor, out_data_o.zero_divisor);
          mismatch_count += 1;
        end
      end
    end
  end

  initial begin
    stamps_t s;
    int      pick;
    logic [31:0] skew;

    // equal stamps give a zero interval sum
    pending_sets.push_back(stamps('0, '0, '0, '0, '0, '0));
    pending_sets.push_back(stamps('1, '1, '1, '1, '1, '1));
    pending_sets.push_back(stamps(32'hA5A5A5A5, 32'hA5A5A5A5, 32'hA5A5A5A5,
                                  32'hA5A5A5A5, 32'hA5A5A5A5, 32'hA5A5A5A5));
    pending_sets.push_back(build_exchange(32'd1000, 32'd5000, 32'd100, 32'd2000,
                                          32'd1000, 32'd0));
    pending_sets.push_back(build_exchange('0, '0, '0, 32'd300, 32'd300, '0));
    // short rounds, long replies: negative flight time
    pending_sets.push_back(stamps(32'd0, 32'd10, 32'd1000000, 32'd0, 32'd1000000,
                                  32'd1000010));
    // last unsaturated distance, then first saturated one
    pending_sets.push_back(build_exchange(32'h12345678, 32'h9ABCDEF0, 32'd139700,
                                          32'd4000, 32'd4000, 32'd0));
    pending_sets.push_back(build_exchange(32'h12345678, 32'h9ABCDEF0, 32'd139701,
                                          32'd4000, 32'd4000, 32'd0));
    pending_sets.push_back(build_exchange(32'd7, 32'd9, 32'd200000, 32'd5000,
                                          32'd5000, 32'd0));
    // counters wrap in the middle of the exchange
    pending_sets.push_back(build_exchange(32'hFFFFFF00, 32'hFFFFFFF0, 32'd500,
                                          32'd1200, 32'd900, 32'd0));
    pending_sets.push_back(stamps('0, '1, 32'hFFFFFFFE, '0, '1, 32'hFFFFFFFE));
    pending_sets.push_back(stamps('0, '1, '1, '0, '0, '1));
    pending_sets.push_back(stamps('0, '1, '1, '0, '0, 32'd1));
    pending_sets.push_back(stamps('0, '0, '1, '0, '1, '1));
    pending_sets.push_back(stamps('0, 32'd1, 32'd1, '0, '0, 32'd1));
    pending_sets.push_back(stamps('0, 32'd2, 32'd2, '0, '0, 32'd2));
    pending_sets.push_back(stamps(32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                                  32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    pending_sets.push_back(stamps(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                                  32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    pending_sets.push_back(build_exchange('0, '0, 32'd50, 32'd3000, 32'd1000,
                                          32'hFFFFFFF0));
    // stamps out of order
    pending_sets.push_back(stamps(32'd1000, 32'd500, 32'd200, 32'd800, 32'd100,
                                  32'd50));
    first_hold  = pending_sets.size();
    second_hold = first_hold + RandomSets / 2;

    for (int i = 0; i < RandomSets; i++) begin
      pick = $urandom_range(0, 99);
      skew = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(0, 64)) - 32'd32;
      s = build_exchange($urandom, $urandom, pick_flight(), pick_reply(), pick_reply(),
                         skew);
      if (pick < 2) begin
        skew = $urandom;
        s = stamps(skew, skew, skew, skew, skew, skew);
      end else if (pick >= 92) begin
        s = stamps($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick >= 82) begin
        // one stamp lost or corrupted
        case ($urandom_range(0, 5))
          0:       s.poll_sent_remote  = $urandom;
          1:       s.reply_got_remote  = $urandom;
          2:       s.final_sent_remote = $urandom;
          3:       s.poll_got_local    = $urandom;
          4:       s.reply_sent_local  = $urandom;
          default: s.final_got_local   = $urandom;
        endcase
      end
      pending_sets.push_back(s);
    end
    sets_total = pending_sets.size();

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (sets_taken != sets_total) @(posedge clk_i);
    while (ranging_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("ran %0d exchanges, %0d results checked", sets_total, results_seen);
    $display("  %0d zero interval sums, %0d saturated distances, %0d negative flights",
             zero_seen, clip_seen, neg_seen);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: %0d of %0d exchanges taken, %0d results outstanding",
             sets_taken, sets_total, ranging_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
